// ===== sv/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int GRP_SHIFT = 3;
  localparam int PAGE_W = 21;
  localparam logic [11:0] PAGE_MASK = 12'hFFF;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RMW_RD,
    ST_RMW_WR
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_write;
    logic grp_inc;
    logic alloc_take;
    logic rmw_write;
    logic finish;
    logic fail;
  } ctl_t;

  typedef struct packed {
    logic grp_end;
    logic grp_at_last;
    logic group_nonzero;
    logic is_alloc;
    logic span_empty;
  } sts_t;

endpackage

// ===== sv/page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Next-fit page-frame allocator over a bitmap of free pages in byte groups.
// ----------------------------------------------------------------------------
//  channel   handshake        word
//  command   start / busy     cmd, addr_first, addr_last
//  result    done (strobe)    page_number, status
//
//  After reset a clearing pass writes every group with busy high. An
//  allocate scans groups upward from the hint; a free updates one group, or
//  none when its page lies beyond the store; a region command does one
//  read-modify-write of the single-port bitmap memory per group touched.
//  The result strobe is registered from the finish of a command, and a new
//  word may be started in the cycle that it is high. The receiver cannot
//  stall.
// ----------------------------------------------------------------------------
module page_bitmap_allocator import pba_pkg::*; #(
  parameter int PAGE_COUNT = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] addr_first,
  input  logic [31:0] addr_last,
  output logic        done,
  output logic [15:0] page_number,
  output logic        status
);

  ctl_t ctl;
  sts_t sts;

  pba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  pba_datapath #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .addr_first  (addr_first),
    .addr_last   (addr_last),
    .ctl         (ctl),
    .sts         (sts),
    .done        (done),
    .page_number (page_number),
    .status      (status)
  );

endmodule

// ===== sv/pba_ctrl.sv =====
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer for the allocator: clearing pass, group scan and group updates.
// ----------------------------------------------------------------------------
module pba_ctrl import pba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr_write = 1'b1;
        if (sts.grp_end) begin
          state_next = ST_IDLE;
        end else begin
          ctl.grp_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_alloc) begin
          state_next = ST_SCAN_RD;
        end else if (sts.span_empty) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_RMW_RD;
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (sts.group_nonzero) begin
          ctl.alloc_take = 1'b1;
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.grp_end) begin
          ctl.finish = 1'b1;
          ctl.fail = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ctl.grp_inc = 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_RMW_RD: begin
        state_next = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        ctl.rmw_write = 1'b1;
        if (sts.grp_at_last) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ctl.grp_inc = 1'b1;
          state_next = ST_RMW_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pba_datapath.sv =====
// ----------------------------------------------------------------------------
// pba_datapath
// Bitmap memory, search hint, group pointer, range decode and result word.
// ----------------------------------------------------------------------------
module pba_datapath import pba_pkg::*; #(
  parameter int PAGE_COUNT = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  cmd,
  input  logic [31:0] addr_first,
  input  logic [31:0] addr_last,
  input  ctl_t        ctl,
  output sts_t        sts,
  output logic        done,
  output logic [15:0] page_number,
  output logic        status
);

  localparam int GROUP_COUNT = (PAGE_COUNT + 7) / 8;
  localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam logic [GW-1:0] GRP_LAST = GW'(GROUP_COUNT - 1);
  localparam logic [PAGE_W-1:0] PAGE_LIMIT = PAGE_W'(PAGE_COUNT);

  logic [7:0] mem [GROUP_COUNT];
  logic [7:0] rdata;
  logic [7:0] wdata;
  logic       mem_we;

  logic [GW-1:0] grp;
  logic [GW-1:0] hint;
  logic [GW-1:0] last_grp;
  logic [2:0]    lo_bit;
  logic [2:0]    hi_bit;
  logic          at_first;
  logic          is_alloc;
  logic          set_mode;
  logic          span_empty_r;

  logic              order_ok;
  logic [PAGE_W-1:0] start_pg;
  logic [PAGE_W-1:0] end_pg;
  logic [PAGE_W-1:0] end_clip;
  logic [PAGE_W-1:0] last_pg;
  logic              span_empty;

  logic [2:0]        low_bit;
  logic [7:0]        low_mask;
  logic [7:0]        rmw_mask;
  logic [2:0]        mask_lo;
  logic [2:0]        mask_hi;
  logic [PAGE_W-1:0] alloc_page;

  always_comb begin
    start_pg = {1'b0, addr_first[31:PAGE_SHIFT]};
    end_pg = start_pg + PAGE_W'(1);
    order_ok = 1'b1;
    unique case (cmd_e_t'(cmd))
      CMD_ALLOC, CMD_FREE: begin
      end
      CMD_RESERVE: begin
        order_ok = addr_first <= addr_last;
        end_pg = {1'b0, addr_last[31:PAGE_SHIFT]} + PAGE_W'(1);
      end
      CMD_RELEASE: begin
        order_ok = addr_first <= addr_last;
        start_pg = PAGE_W'((33'(addr_first) + 33'(PAGE_MASK)) >> PAGE_SHIFT);
        end_pg = PAGE_W'((33'(addr_last) + 33'd1) >> PAGE_SHIFT);
      end
      default: begin
      end
    endcase
    end_clip = (end_pg > PAGE_LIMIT) ? PAGE_LIMIT : end_pg;
    span_empty = !order_ok || (start_pg >= end_clip);
    last_pg = end_clip - PAGE_W'(1);
  end

  always_comb begin
    low_bit = 3'd7;
    for (int b = 6; b >= 0; b--) begin
      if (rdata[b]) begin
        low_bit = 3'(b);
      end
    end
    low_mask = 8'd1 << low_bit;
    alloc_page = PAGE_W'({grp, low_bit});
    mask_lo = at_first ? lo_bit : 3'd0;
    mask_hi = (grp == last_grp) ? hi_bit : 3'd7;
    for (int b = 0; b < 8; b++) begin
      rmw_mask[b] = (3'(b) >= mask_lo) && (3'(b) <= mask_hi);
    end
  end

  always_comb begin
    mem_we = ctl.clr_write | ctl.alloc_take | ctl.rmw_write;
    priority if (ctl.clr_write) begin
      wdata = 8'd0;
    end else if (ctl.alloc_take) begin
      wdata = rdata & ~low_mask;
    end else if (set_mode) begin
      wdata = rdata | rmw_mask;
    end else begin
      wdata = rdata & ~rmw_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[grp] <= wdata;
    end
    rdata <= mem[grp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp <= '0;
      hint <= '0;
      at_first <= 1'b0;
      is_alloc <= 1'b0;
      span_empty_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.load) begin
        is_alloc <= cmd_e_t'(cmd) == CMD_ALLOC;
        span_empty_r <= span_empty;
        at_first <= 1'b1;
        grp <= (cmd_e_t'(cmd) == CMD_ALLOC) ? hint : start_pg[GRP_SHIFT +: GW];
        if ((cmd_e_t'(cmd) == CMD_FREE) && !span_empty) begin
          hint <= start_pg[GRP_SHIFT +: GW];
        end
      end else if (ctl.grp_inc) begin
        grp <= grp + GW'(1);
        at_first <= 1'b0;
      end
      if (ctl.alloc_take) begin
        hint <= grp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      set_mode <= cmd_e_t'(cmd) != CMD_RESERVE;
      lo_bit <= start_pg[2:0];
      hi_bit <= last_pg[2:0];
      last_grp <= last_pg[GRP_SHIFT +: GW];
    end
    if (ctl.finish) begin
      page_number <= ctl.alloc_take ? alloc_page[15:0] : 16'd0;
      status <= ctl.fail;
    end
  end

  assign sts.grp_end = grp == GRP_LAST;
  assign sts.grp_at_last = grp == last_grp;
  assign sts.group_nonzero = rdata != 8'd0;
  assign sts.is_alloc = is_alloc;
  assign sts.span_empty = span_empty_r;

endmodule
